@@ rtl/fbrdt_pkg.sv @@
package fbrdt_pkg;

    localparam int ScreenWidth  = 128;
    localparam int ScreenHeight = 64;
    localparam int QueueDepth   = 2;

    typedef enum logic [2:0] {
        CMD_PIXEL = 3'd0,
        CMD_LINE  = 3'd1,
        CMD_WRITE = 3'd2,
        CMD_READ  = 3'd3,
        CMD_CLEAR = 3'd4,
        CMD_TAKE  = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LINE_RD,
        ST_LINE_WR,
        ST_READ_WAIT,
        ST_CLEAR,
        ST_REPORT
    } t_state;

    typedef struct packed {
        logic [2:0] command;
        logic [6:0] start_x;
        logic [5:0] start_y;
        logic [6:0] end_x;
        logic [5:0] end_y;
        logic       color;
        logic [7:0] byte_data;
    } t_item;

endpackage

@@ rtl/framebuffer_raster_dirty_track.sv @@
// Frame store with pixel, line, byte and clear commands and dirty bounds.
// Command channel: drive i_command and operands with start high; the
// transaction is taken on a rising edge where busy is low. A two-entry
// queue sits ahead of the executor, so a command can be taken while the
// previous one still runs.
// Result channel: every command gives exactly one result, shown for one
// cycle with o_strobe high; the receiver cannot stall it.
// Steps after the executor picks a command up:
//   pixel: a read and a write of its byte, line: the same for each point,
//   write byte / take bounds / unused: straight to the result, read byte:
//   a read-wait state first, clear all: the single memory write port
//   sweeps the store one byte a cycle. Every command ends in its result.
// Each line point goes through a read state and then a write state.
// After each result the executor returns to its idle state, where it
// picks up the next queued command.
// After reset the executor sweeps the store to zero before it picks up
// the first queued command; commands are still queued.
module framebuffer_raster_dirty_track
    import fbrdt_pkg::*;
#(
    parameter int SCREEN_WIDTH  = ScreenWidth,
    parameter int SCREEN_HEIGHT = ScreenHeight
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] i_command,
    input  logic [6:0] i_start_x,
    input  logic [5:0] i_start_y,
    input  logic [6:0] i_end_x,
    input  logic [5:0] i_end_y,
    input  logic       i_color,
    input  logic [7:0] i_byte_data,
    output logic       o_strobe,
    output logic [7:0] o_read_data,
    output logic       o_dirty_valid,
    output logic [6:0] o_dirty_left,
    output logic [6:0] o_dirty_right,
    output logic [2:0] o_dirty_top,
    output logic [2:0] o_dirty_bottom
);

    t_item in_item, q_item;
    logic  q_valid, q_pop;

    assign in_item = '{command: i_command, start_x: i_start_x, start_y: i_start_y,
                       end_x: i_end_x, end_y: i_end_y, color: i_color,
                       byte_data: i_byte_data};

    fbrdt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (in_item),
        .i_pop   (q_pop),
        .o_busy  (busy),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    fbrdt_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .i_item         (q_item),
        .o_pop          (q_pop),
        .o_strobe       (o_strobe),
        .o_read_data    (o_read_data),
        .o_dirty_valid  (o_dirty_valid),
        .o_dirty_left   (o_dirty_left),
        .o_dirty_right  (o_dirty_right),
        .o_dirty_top    (o_dirty_top),
        .o_dirty_bottom (o_dirty_bottom)
    );

endmodule

@@ rtl/fbrdt_front.sv @@
module fbrdt_front
    import fbrdt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_busy,
    output logic  o_valid,
    output t_item o_item
);

    t_item      r_q [QueueDepth];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       r_wr;
    logic       w_push;

    assign o_busy  = (r_cnt == 2'(QueueDepth));
    assign w_push  = i_start && !o_busy;
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= i_item;
        end
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (w_push) r_wr <= !r_wr;
            if (i_pop) r_rd <= !r_rd;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop);
        end
    end

endmodule

@@ rtl/fbrdt_back.sv @@
module fbrdt_back
    import fbrdt_pkg::*;
#(
    parameter int SCREEN_WIDTH  = ScreenWidth,
    parameter int SCREEN_HEIGHT = ScreenHeight
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_item      i_item,
    output logic       o_pop,
    output logic       o_strobe,
    output logic [7:0] o_read_data,
    output logic       o_dirty_valid,
    output logic [6:0] o_dirty_left,
    output logic [6:0] o_dirty_right,
    output logic [2:0] o_dirty_top,
    output logic [2:0] o_dirty_bottom
);

    localparam int Pages = (SCREEN_HEIGHT + 7) / 8;
    localparam int Depth = SCREEN_WIDTH * Pages;
    localparam int AW    = $clog2(Depth);

    logic [7:0] mem [Depth];
    logic [7:0] r_rdata;

    t_state r_state, n_state;
    logic [AW:0] r_clr, n_clr;
    logic [8:0]  r_x, n_x, r_y, n_y;
    logic [8:0]  r_ex, n_ex, r_ey, n_ey;
    logic signed [10:0] r_acc, n_acc, r_dx, n_dx, r_dy, n_dy;
    logic r_sx, n_sx, r_sy, n_sy, r_xmaj, n_xmaj, r_col, n_col;
    logic [7:0] r_rd, n_rd;
    logic       r_mv, n_mv;
    logic [6:0] r_ml, n_ml, r_mr, n_mr;
    logic [2:0] r_mt, n_mt, r_mb, n_mb;
    logic       r_take, n_take;
    logic       r_clr_cmd;

    logic             we, re;
    logic [AW-1:0]    waddr, raddr;
    logic [7:0]       wdata;
    logic             mk;
    logic [6:0]       mk_c;
    logic [2:0]       mk_p;
    logic [8:0]       cx, cy;
    logic             on;
    logic [AW-1:0]    paddr;
    logic [7:0]       bmask;
    logic signed [10:0] adx, ady;
    logic [8:0]       nx, ny;
    logic signed [10:0] nacc;
    logic             done;

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        if (re) r_rdata <= mem[raddr];
    end

    function automatic logic [AW-1:0] addr_of(logic [8:0] col, logic [8:0] page);
        addr_of = AW'(32'(page) * SCREEN_WIDTH + 32'(col));
    endfunction

    always_comb begin
        n_state = r_state; n_clr = r_clr; n_x = r_x; n_y = r_y;
        n_ex = r_ex; n_ey = r_ey; n_acc = r_acc; n_dx = r_dx; n_dy = r_dy;
        n_sx = r_sx; n_sy = r_sy; n_xmaj = r_xmaj; n_col = r_col;
        n_rd = r_rd; n_mv = r_mv; n_ml = r_ml; n_mr = r_mr; n_mt = r_mt;
        n_mb = r_mb; n_take = r_take;
        we = 1'b0; re = 1'b0; waddr = '0; raddr = '0; wdata = '0;
        mk = 1'b0; mk_c = '0; mk_p = '0; o_pop = 1'b0;
        cx = r_x; cy = r_y;
        on = (cx < 9'(SCREEN_WIDTH)) && (cy < 9'(SCREEN_HEIGHT));
        paddr = addr_of(cx, {3'd0, cy[8:3]});
        bmask = 8'd1 << cy[2:0];
        adx = 11'(i_item.end_x) - 11'(i_item.start_x);
        ady = 11'(i_item.end_y) - 11'(i_item.start_y);
        done = r_xmaj ? (r_x == r_ex) : (r_y == r_ey);
        nx = r_x; ny = r_y; nacc = r_acc;
        if (r_xmaj) begin
            if (r_acc >= 0) begin
                ny = r_sy ? r_y - 9'd1 : r_y + 9'd1;
                nacc = r_acc - r_dx;
            end
            nx = r_sx ? r_x - 9'd1 : r_x + 9'd1;
            nacc = nacc + r_dy;
        end else begin
            if (r_acc >= 0) begin
                nx = r_sx ? r_x - 9'd1 : r_x + 9'd1;
                nacc = r_acc - r_dy;
            end
            ny = r_sy ? r_y - 9'd1 : r_y + 9'd1;
            nacc = nacc + r_dx;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_pop  = 1'b1;
                    n_rd   = '0;
                    n_take = 1'b0;
                    n_col  = i_item.color;
                    n_state = ST_REPORT;
                    case (i_item.command)
                        CMD_PIXEL, CMD_LINE: begin
                            n_x = 9'(i_item.start_x);
                            n_y = 9'(i_item.start_y);
                            n_ex = (i_item.command == CMD_LINE) ?
                                9'(i_item.end_x) : 9'(i_item.start_x);
                            n_ey = (i_item.command == CMD_LINE) ?
                                9'(i_item.end_y) : 9'(i_item.start_y);
                            n_sx = adx < 0;
                            n_sy = ady < 0;
                            if (i_item.command != CMD_LINE) begin
                                n_sx = 1'b0; n_sy = 1'b0;
                                adx = '0; ady = '0;
                            end
                            if (adx < 0) adx = -adx;
                            if (ady < 0) ady = -ady;
                            n_dx = adx <<< 1;
                            n_dy = ady <<< 1;
                            n_xmaj = (adx > ady);
                            n_acc = n_xmaj ? (n_dy - adx) : (n_dx - ady);
                            n_state = ST_LINE_RD;
                        end
                        CMD_WRITE: begin
                            if (9'(i_item.start_x) < 9'(SCREEN_WIDTH) &&
                                9'(i_item.start_y) < 9'(Pages)) begin
                                we = 1'b1;
                                waddr = addr_of(9'(i_item.start_x), 9'(i_item.start_y));
                                wdata = i_item.byte_data;
                                mk = 1'b1;
                                mk_c = i_item.start_x;
                                mk_p = 3'(i_item.start_y);
                            end
                        end
                        CMD_READ: begin
                            if (9'(i_item.start_x) < 9'(SCREEN_WIDTH) &&
                                9'(i_item.start_y) < 9'(Pages)) begin
                                re = 1'b1;
                                raddr = addr_of(9'(i_item.start_x), 9'(i_item.start_y));
                                n_state = ST_READ_WAIT;
                            end
                        end
                        CMD_CLEAR: begin
                            n_clr = '0;
                            n_state = ST_CLEAR;
                        end
                        CMD_TAKE: n_take = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_LINE_RD: begin
                re = on;
                raddr = paddr;
                n_state = ST_LINE_WR;
            end
            ST_LINE_WR: begin
                if (on) begin
                    we = 1'b1;
                    waddr = paddr;
                    wdata = r_col ? (r_rdata | bmask) : (r_rdata & ~bmask);
                    mk = 1'b1;
                    mk_c = cx[6:0];
                    mk_p = cy[5:3];
                end
                if (done) begin
                    n_state = ST_REPORT;
                end else begin
                    n_x = nx; n_y = ny; n_acc = nacc;
                    n_state = ST_LINE_RD;
                end
            end
            ST_READ_WAIT: begin
                n_rd = r_rdata;
                n_state = ST_REPORT;
            end
            ST_CLEAR: begin
                we = 1'b1;
                waddr = r_clr[AW-1:0];
                n_clr = r_clr + (AW+1)'(1);
                if (r_clr == (AW+1)'(Depth - 1)) n_state = ST_REPORT;
            end
            ST_REPORT: begin
                n_state = ST_IDLE;
                if (r_take) begin
                    n_mv = 1'b0; n_ml = 7'(SCREEN_WIDTH - 1); n_mr = '0;
                    n_mt = 3'(Pages - 1); n_mb = '0;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (mk) begin
            if (!r_mv) begin
                n_mv = 1'b1; n_ml = mk_c; n_mr = mk_c; n_mt = mk_p; n_mb = mk_p;
            end else begin
                if (mk_c < r_ml) n_ml = mk_c;
                if (mk_c > r_mr) n_mr = mk_c;
                if (mk_p < r_mt) n_mt = mk_p;
                if (mk_p > r_mb) n_mb = mk_p;
            end
        end
    end

    assign o_strobe       = (r_state == ST_REPORT);
    assign o_read_data    = r_rd;
    assign o_dirty_valid  = r_mv;
    assign o_dirty_left   = r_mv ? r_ml : '0;
    assign o_dirty_right  = r_mv ? r_mr : '0;
    assign o_dirty_top    = r_mv ? r_mt : '0;
    assign o_dirty_bottom = r_mv ? r_mb : '0;

    always_ff @(posedge i_clk) begin
        r_x <= n_x; r_y <= n_y; r_ex <= n_ex; r_ey <= n_ey;
        r_acc <= n_acc; r_dx <= n_dx; r_dy <= n_dy; r_sx <= n_sx; r_sy <= n_sy;
        r_xmaj <= n_xmaj; r_col <= n_col; r_rd <= n_rd;
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_mv    <= 1'b0;
            r_ml    <= 7'(SCREEN_WIDTH - 1);
            r_mr    <= '0;
            r_mt    <= 3'(Pages - 1);
            r_mb    <= '0;
            r_take  <= 1'b0;
        end else begin
            r_state <= (r_state == ST_CLEAR && n_state == ST_REPORT && !r_clr_cmd) ?
                ST_IDLE : n_state;
            r_clr  <= n_clr;
            r_take <= n_take;
            r_mv <= n_mv; r_ml <= n_ml; r_mr <= n_mr; r_mt <= n_mt; r_mb <= n_mb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr_cmd <= 1'b0;
        else if (r_state == ST_IDLE && o_pop) r_clr_cmd <= (i_item.command == CMD_CLEAR);
    end

endmodule

@@ test/tb_framebuffer_raster_dirty_track.sv @@
module tb_framebuffer_raster_dirty_track;
    import fbrdt_pkg::*;

    typedef struct {
        logic [7:0] read_data;
        logic       dirty_valid;
        logic [6:0] dirty_left;
        logic [6:0] dirty_right;
        logic [2:0] dirty_top;
        logic [2:0] dirty_bottom;
    } t_report;

    localparam int PageCount  = ScreenHeight / 8;
    localparam int StoreBytes = ScreenWidth * PageCount;
    localparam int CycleLimit = 10000000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [2:0] i_command = '0;
    logic [6:0] i_start_x = '0;
    logic [5:0] i_start_y = '0;
    logic [6:0] i_end_x = '0;
    logic [5:0] i_end_y = '0;
    logic       i_color = 1'b0;
    logic [7:0] i_byte_data = '0;
    logic       o_strobe;
    logic [7:0] o_read_data;
    logic       o_dirty_valid;
    logic [6:0] o_dirty_left;
    logic [6:0] o_dirty_right;
    logic [2:0] o_dirty_top;
    logic [2:0] o_dirty_bottom;

    framebuffer_raster_dirty_track dut (.*);

    always #6 i_clk = ~i_clk;

    t_item   pending_cmds[$];
    t_report expected_reports[$];
    logic [7:0] shadow_store[StoreBytes];
    logic [6:0] box_left = 7'd127;
    logic [6:0] box_right = 7'd0;
    logic [2:0] box_top = 3'd7;
    logic [2:0] box_bottom = 3'd0;
    logic       box_valid = 1'b0;
    int  errors = 0;
    int  cycles = 0;
    bit  hold_off = 1'b0;
    int  burst_left = 0;
    int  gap_left = 0;

    function automatic void widen_box(int col, int page);
        if (col > ScreenWidth - 1) col = ScreenWidth - 1;
        if (page > PageCount - 1) page = PageCount - 1;
        if (!box_valid) begin
            box_left = 7'(col);
            box_right = 7'(col);
            box_top = 3'(page);
            box_bottom = 3'(page);
            box_valid = 1'b1;
        end else begin
            if (col < box_left) box_left = 7'(col);
            if (col > box_right) box_right = 7'(col);
            if (page < box_top) box_top = 3'(page);
            if (page > box_bottom) box_bottom = 3'(page);
        end
    endfunction

    function automatic void put_pixel(int x, int y, logic color);
        int idx;
        if (x < 0 || y < 0 || x >= ScreenWidth || y >= ScreenHeight) return;
        idx = (y / 8) * ScreenWidth + x;
        shadow_store[idx][y % 8] = color;
        widen_box(x, y / 8);
    endfunction

    function automatic void trace_line(int x0, int y0, int x1, int y1, logic color);
        int dx, dy, sx, sy, acc;
        dx = x1 - x0;
        dy = y1 - y0;
        sx = 1;
        sy = 1;
        if (dy < 0) begin dy = -dy; sy = -1; end
        if (dx < 0) begin dx = -dx; sx = -1; end
        dx *= 2;
        dy *= 2;
        put_pixel(x0, y0, color);
        if (dx > dy) begin
            acc = dy - dx / 2;
            while (x0 != x1) begin
                if (acc >= 0) begin y0 += sy; acc -= dx; end
                x0 += sx;
                acc += dy;
                put_pixel(x0, y0, color);
            end
        end else begin
            acc = dx - dy / 2;
            while (y0 != y1) begin
                if (acc >= 0) begin x0 += sx; acc -= dy; end
                y0 += sy;
                acc += dx;
                put_pixel(x0, y0, color);
            end
        end
    endfunction

    function automatic t_report apply_command(t_item c);
        t_report r;
        r.read_data = '0;
        case (c.command)
            CMD_PIXEL: put_pixel(c.start_x, c.start_y, c.color);
            CMD_LINE:  trace_line(c.start_x, c.start_y, c.end_x, c.end_y, c.color);
            CMD_WRITE: begin
                if (c.start_y < PageCount) begin
                    shadow_store[c.start_y * ScreenWidth + c.start_x] = c.byte_data;
                    widen_box(c.start_x, c.start_y);
                end
            end
            CMD_READ: begin
                if (c.start_y < PageCount)
                    r.read_data = shadow_store[c.start_y * ScreenWidth + c.start_x];
            end
            CMD_CLEAR: begin
                foreach (shadow_store[i]) shadow_store[i] = '0;
            end
            default: ;
        endcase
        r.dirty_valid  = box_valid;
        r.dirty_left   = box_valid ? box_left : '0;
        r.dirty_right  = box_valid ? box_right : '0;
        r.dirty_top    = box_valid ? box_top : '0;
        r.dirty_bottom = box_valid ? box_bottom : '0;
        if (c.command == CMD_TAKE) begin
            box_left = 7'd127;
            box_right = 7'd0;
            box_top = 3'd7;
            box_bottom = 3'd0;
            box_valid = 1'b0;
        end
        return r;
    endfunction

    function automatic t_item make_cmd(logic [2:0] cmd, int sx, int sy, int ex, int ey,
                                       logic color, int data);
        t_item c;
        c.command = cmd;
        c.start_x = 7'(sx);
        c.start_y = 6'(sy);
        c.end_x = 7'(ex);
        c.end_y = 6'(ey);
        c.color = color;
        c.byte_data = 8'(data);
        return c;
    endfunction

    function automatic t_item random_cmd();
        t_item c;
        int pick;
        c = make_cmd(3'($urandom_range(7, 0)), $urandom_range(127, 0),
                     $urandom_range(63, 0), $urandom_range(127, 0),
                     $urandom_range(63, 0), 1'($urandom_range(1, 0)),
                     $urandom_range(255, 0));
        pick = $urandom_range(99, 0);
        if (pick < 25) c.command = CMD_PIXEL;
        else if (pick < 40) c.command = CMD_LINE;
        else if (pick < 55) c.command = CMD_WRITE;
        else if (pick < 80) c.command = CMD_READ;
        else if (pick < 81) c.command = CMD_CLEAR;
        else if (pick < 93) c.command = CMD_TAKE;
        if (c.command == CMD_LINE && $urandom_range(3, 0) != 0) begin
            c.end_x = 7'(c.start_x + $urandom_range(16, 0) - 8);
            c.end_y = 6'(c.start_y + $urandom_range(16, 0) - 8);
        end
        if ((c.command == CMD_WRITE || c.command == CMD_READ) && $urandom_range(7, 0) != 0)
            c.start_y = 6'($urandom_range(PageCount - 1, 0));
        return c;
    endfunction

    initial begin
        foreach (shadow_store[i]) shadow_store[i] = '0;
        pending_cmds.push_back(make_cmd(CMD_TAKE, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_PIXEL, 0, 0, 0, 0, 1, 0));
        pending_cmds.push_back(make_cmd(CMD_PIXEL, 127, 63, 127, 63, 1, 255));
        pending_cmds.push_back(make_cmd(CMD_READ, 127, 7, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_PIXEL, 127, 63, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_TAKE, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_LINE, 5, 5, 5, 5, 1, 0));
        pending_cmds.push_back(make_cmd(CMD_LINE, 0, 0, 127, 63, 1, 0));
        pending_cmds.push_back(make_cmd(CMD_LINE, 127, 0, 0, 63, 1, 0));
        pending_cmds.push_back(make_cmd(CMD_LINE, 10, 60, 20, 50, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_LINE, 3, 40, 40, 3, 1, 0));
        pending_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_TAKE, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_WRITE, 64, 3, 0, 0, 0, 8'hA5));
        pending_cmds.push_back(make_cmd(CMD_WRITE, 64, 8, 0, 0, 0, 8'h5A));
        pending_cmds.push_back(make_cmd(CMD_WRITE, 127, 63, 0, 0, 1, 8'hFF));
        pending_cmds.push_back(make_cmd(CMD_READ, 64, 3, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_READ, 64, 63, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_READ, 64, 3, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(3'd6, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(3'd7, 127, 63, 127, 63, 1, 255));
        pending_cmds.push_back(make_cmd(CMD_TAKE, 0, 0, 0, 0, 0, 0));
        for (int i = 0; i < 1800; i++) pending_cmds.push_back(random_cmd());
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            expected_reports.push_back(apply_command({i_command, i_start_x, i_start_y,
                                                      i_end_x, i_end_y, i_color,
                                                      i_byte_data}));
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && busy) begin
            start <= 1'b1;
        end else if (hold_off) begin
            start <= 1'b0;
            if (expected_reports.size() == 0 && !(start && !busy)) hold_off <= 1'b0;
        end else if (pending_cmds.size() == 0) begin
            start <= 1'b0;
        end else if (gap_left > 0) begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
        end else begin
            start <= 1'b1;
            {i_command, i_start_x, i_start_y, i_end_x, i_end_y, i_color, i_byte_data}
                <= pending_cmds.pop_front();
            if (pending_cmds.size() == 900) hold_off <= 1'b1;
            if (burst_left == 0) begin
                burst_left <= $urandom_range(20, 1);
                gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
            end else begin
                burst_left <= burst_left - 1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_report want;
        if (i_rst_n && o_strobe) begin
            if (expected_reports.size() == 0) begin
                $error("unexpected transaction");
                errors++;
            end else begin
                want = expected_reports.pop_front();
                if (o_read_data !== want.read_data) begin
                    $error("read_data exp %0h got %0h", want.read_data, o_read_data);
                    errors++;
                end
                if (o_dirty_valid !== want.dirty_valid) begin
                    $error("dirty_valid exp %0d got %0d", want.dirty_valid, o_dirty_valid);
                    errors++;
                end
                if (o_dirty_left !== want.dirty_left) begin
                    $error("dirty_left exp %0d got %0d", want.dirty_left, o_dirty_left);
                    errors++;
                end
                if (o_dirty_right !== want.dirty_right) begin
                    $error("dirty_right exp %0d got %0d", want.dirty_right, o_dirty_right);
                    errors++;
                end
                if (o_dirty_top !== want.dirty_top) begin
                    $error("dirty_top exp %0d got %0d", want.dirty_top, o_dirty_top);
                    errors++;
                end
                if (o_dirty_bottom !== want.dirty_bottom) begin
                    $error("dirty_bottom exp %0d got %0d", want.dirty_bottom,
                           o_dirty_bottom);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("FAIL framebuffer_raster_dirty_track");
            $finish;
        end
    end

    initial begin
        wait (i_rst_n);
        wait (pending_cmds.size() == 0 && !start);
        wait (expected_reports.size() == 0);
        repeat (1100) @(posedge i_clk);
        if (errors == 0 && expected_reports.size() == 0) begin
            $display("PASS framebuffer_raster_dirty_track");
        end else begin
            $display("FAIL framebuffer_raster_dirty_track");
        end
        $finish;
    end
endmodule

@@ sim.f @@
rtl/fbrdt_pkg.sv
rtl/fbrdt_front.sv
rtl/fbrdt_back.sv
rtl/framebuffer_raster_dirty_track.sv
test/tb_framebuffer_raster_dirty_track.sv
